### rtl/psc_pkg.sv
// Shared types, constants and the pixel-to-index function of the span encoder.
package psc_pkg;

  localparam int NUM_PIXELS  = 8;
  localparam int PIX_W       = 24;
  localparam int IDX_W       = 4;

  localparam logic [IDX_W-1:0] FG_DEFAULT = 4'd10;
  localparam logic [IDX_W-1:0] BG_DEFAULT = 4'd0;

  // Payload of one span as it travels down the cell row.
  typedef struct packed {
    logic                                mode;
    logic [IDX_W-1:0]                    fg;
    logic                                fg_ok;
    logic [IDX_W-1:0]                    bg;
    logic                                bg_ok;
    logic [NUM_PIXELS-1:0]               pattern;
    logic [NUM_PIXELS-1:0][IDX_W-1:0]    idx;
  } span_t;

  // Map an RGB value to its 16-color index.
  function automatic logic [IDX_W-1:0] pixel_index(input logic [PIX_W-1:0] rgb);
    logic [IDX_W-1:0] c;
    case (rgb)
      24'hFFFFFF:             c = 4'd15;
      24'hFFFF00:             c = 4'd14;
      24'hFF00FF:             c = 4'd13;
      24'hFF0000:             c = 4'd12;
      24'h00FFFF:             c = 4'd11;
      24'h00FF00:             c = 4'd10;
      24'h0000FF:             c = 4'd9;
      24'hC0C0C0, 24'h808080: c = 4'd7;
      24'hC0C000, 24'h808000: c = 4'd6;
      24'hC000C0, 24'h800080: c = 4'd5;
      24'hC00000, 24'h800000: c = 4'd4;
      24'h00C0C0, 24'h008080: c = 4'd3;
      24'h00C000, 24'h008000: c = 4'd2;
      24'h0000C0, 24'h000080: c = 4'd1;
      default:                c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/psc_map.sv
// Entry stage: register the color indices of all eight pixels and the mode.
module psc_map (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        take,
  input  logic                                        mode,
  input  logic [psc_pkg::NUM_PIXELS-1:0][psc_pkg::PIX_W-1:0] pixels,
  output logic                                        valid_o,
  output psc_pkg::span_t                              span_o
);

  logic           valid_r;
  psc_pkg::span_t span_r;
  psc_pkg::span_t span_nxt;

  always_comb begin
    span_nxt         = '0;
    span_nxt.mode    = mode;
    span_nxt.fg      = 4'd0;
    span_nxt.bg      = 4'd0;
    for (int i = 0; i < psc_pkg::NUM_PIXELS; i++) begin
      span_nxt.idx[i] = psc_pkg::pixel_index(pixels[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      span_r <= span_nxt;
    end
  end

  assign valid_o = valid_r;
  assign span_o  = span_r;

endmodule

### rtl/psc_cell.sv
// One scan cell: resolve the leading pixel's bit, update colors, shift the span on.
module psc_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  psc_pkg::span_t span_i,
  output logic           valid_o,
  output psc_pkg::span_t span_o
);

  logic                      valid_r;
  psc_pkg::span_t            span_r;
  psc_pkg::span_t            span_nxt;
  logic [psc_pkg::IDX_W-1:0] c;
  logic                      bit_v;
  logic                      is_fg;
  logic                      is_bg;

  always_comb begin
    span_nxt = span_i;
    c        = span_i.idx[0];
    is_fg    = span_i.fg_ok && (c == span_i.fg);
    is_bg    = span_i.bg_ok && (c == span_i.bg);
    bit_v    = 1'b0;
    if (span_i.mode) begin
      if (is_fg) begin
        bit_v = 1'b1;
      end else if (is_bg) begin
        bit_v = 1'b0;
      end else if ((c == 4'd0) && !span_i.bg_ok) begin
        span_nxt.bg    = 4'd0;
        span_nxt.bg_ok = 1'b1;
      end else if (!span_i.fg_ok) begin
        span_nxt.fg    = c;
        span_nxt.fg_ok = 1'b1;
        bit_v          = 1'b1;
      end else if (!span_i.bg_ok) begin
        span_nxt.bg    = c;
        span_nxt.bg_ok = 1'b1;
      end else if (span_i.fg != 4'd0) begin
        // Smaller index takes over the foreground; earlier bits stand.
        if (c < span_i.fg) begin
          span_nxt.fg = c;
        end
        bit_v = 1'b1;
      end
    end else begin
      bit_v = (c != 4'd0);
    end
    span_nxt.pattern = {span_i.pattern[psc_pkg::NUM_PIXELS-2:0], bit_v};
    // Advance the index lanes so the next pixel leads.
    span_nxt.idx = {psc_pkg::IDX_W'(0), span_i.idx[psc_pkg::NUM_PIXELS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i) begin
      span_r <= span_nxt;
    end
  end

  assign valid_o = valid_r;
  assign span_o  = span_r;

endmodule

### rtl/pixel_span_two_color_encoder.sv
// Top level of the eight-pixel two-color span encoder.
// Path: the result of an accepted beat reaches the out_ ports through one entry stage that
//   maps pixels, then one cell per pixel, each of them registered.
// Throughput: one span per cycle; every stage advances each cycle, so busy is low after reset.
// Reset: rst_n is synchronous, active low; it clears all stage valids and color_mode, and holds
//   busy high (cfg_ready low) through reset and the cycle after it. The receiver cannot stall.
module pixel_span_two_color_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_pixel_0,
  input  logic [23:0] in_pixel_1,
  input  logic [23:0] in_pixel_2,
  input  logic [23:0] in_pixel_3,
  input  logic [23:0] in_pixel_4,
  input  logic [23:0] in_pixel_5,
  input  logic [23:0] in_pixel_6,
  input  logic [23:0] in_pixel_7,
  // result channel
  output logic        out_valid,
  output logic [7:0]  out_pattern,
  output logic [3:0]  out_fore_color,
  output logic [3:0]  out_back_color,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int N = psc_pkg::NUM_PIXELS;

  logic                                   busy_r;
  logic                                   color_mode_r;
  logic                                   take;
  logic [N-1:0][psc_pkg::PIX_W-1:0]       pixels;
  logic [N:0]                             stage_valid;
  psc_pkg::span_t                         stage_span [N+1];
  psc_pkg::span_t                         last_span;

  // Busy is a registered copy of reset; the row takes a beat every cycle that busy is low.
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign take      = start && !busy_r;

  // Mode register, latched per span at entry; user writes only while the row is empty (unchecked).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      color_mode_r <= cfg_data;
    end
  end

  // pixel_0 is leftmost and is scanned first, so it sits in lane 0.
  assign pixels[0] = in_pixel_0;
  assign pixels[1] = in_pixel_1;
  assign pixels[2] = in_pixel_2;
  assign pixels[3] = in_pixel_3;
  assign pixels[4] = in_pixel_4;
  assign pixels[5] = in_pixel_5;
  assign pixels[6] = in_pixel_6;
  assign pixels[7] = in_pixel_7;

  psc_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .mode    (color_mode_r),
    .pixels  (pixels),
    .valid_o (stage_valid[0]),
    .span_o  (stage_span[0])
  );

  // One cell per pixel; each consumes the leading lane and hands the span on.
  for (genvar g = 0; g < N; g++) begin : g_cell
    psc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (stage_valid[g]),
      .span_i  (stage_span[g]),
      .valid_o (stage_valid[g+1]),
      .span_o  (stage_span[g+1])
    );
  end

  assign last_span = stage_span[N];

  // Drive the result straight off the last cell; fill in defaults for unassigned colors.
  assign out_valid      = stage_valid[N];
  assign out_pattern    = last_span.pattern;
  assign out_fore_color = last_span.fg_ok ? last_span.fg : psc_pkg::FG_DEFAULT;
  assign out_back_color = last_span.bg_ok ? last_span.bg : psc_pkg::BG_DEFAULT;

endmodule

### rtl/psc_checker.sv
// Port-level checks of the span encoder, bound to its top level.
module psc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [7:0]  out_pattern,
  input logic [3:0]  out_fore_color,
  input logic [3:0]  out_back_color
);

  // Every accepted beat yields exactly one result once it has passed the entry stage and every cell.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##9 out_valid)
    else $error("accepted span produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 9))
    else $error("result without an accepted span");

  // An all-background pattern means no foreground was ever assigned.
  a_empty_pattern_fg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_pattern == 8'd0)) |-> (out_fore_color == psc_pkg::FG_DEFAULT))
    else $error("empty pattern with assigned foreground");

  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_pattern, out_fore_color, out_back_color}))
    else $error("result fields unknown");

  a_busy_after_reset: assert property (@(posedge clk)
    rst_n |=> !busy)
    else $error("busy held outside reset");

endmodule

bind pixel_span_two_color_encoder psc_checker u_psc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_pattern    (out_pattern),
  .out_fore_color (out_fore_color),
  .out_back_color (out_back_color)
);

### tb/sv/pixel_span_two_color_encoder_tb.sv
// Self-checking testbench for the eight-pixel two-color span encoder.
`timescale 1ns / 100ps

module pixel_span_two_color_encoder_tb;

  // Mode register values.
  localparam bit MODE_MONO  = 1'b0;
  localparam bit MODE_COLOR = 1'b1;

  // Intensity levels that make up the palette.
  localparam logic [7:0] LVL_FULL   = 8'hFF;
  localparam logic [7:0] LVL_BRIGHT = 8'hC0;
  localparam logic [7:0] LVL_DARK   = 8'h80;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int PIPE_LATENCY   = 9;
  localparam int WATCHDOG_LIMIT = 500;

  // Pixel 0 (leftmost) sits at index 0.
  typedef logic [0:psc_pkg::NUM_PIXELS-1][psc_pkg::PIX_W-1:0] span_pix_t;

  typedef struct packed {
    logic [7:0] pattern;
    logic [3:0] fore;
    logic [3:0] back;
  } span_code_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [23:0] in_pixel_0, in_pixel_1, in_pixel_2, in_pixel_3;
  logic [23:0] in_pixel_4, in_pixel_5, in_pixel_6, in_pixel_7;
  logic        out_valid;
  logic [7:0]  out_pattern;
  logic [3:0]  out_fore_color;
  logic [3:0]  out_back_color;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  // Encoded spans waiting to come out of the block, oldest first.
  span_code_t awaited_codes[$];

  bit color_mode_shadow;
  bit idle_en;
  int errors;
  int spans_accepted;
  int mono_spans;
  int color_spans;
  int codes_checked;
  int mode_writes;
  int stall_cycles;

  pixel_span_two_color_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_0     (in_pixel_0),
    .in_pixel_1     (in_pixel_1),
    .in_pixel_2     (in_pixel_2),
    .in_pixel_3     (in_pixel_3),
    .in_pixel_4     (in_pixel_4),
    .in_pixel_5     (in_pixel_5),
    .in_pixel_6     (in_pixel_6),
    .in_pixel_7     (in_pixel_7),
    .out_valid      (out_valid),
    .out_pattern    (out_pattern),
    .out_fore_color (out_fore_color),
    .out_back_color (out_back_color),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Color index of one RGB value. A palette color has every channel either off
  // or at one common level; the level picks the upper half (full) or the lower
  // half (bright or dark) of the index range, the lit channels give the low bits.
  // Black, anything with mixed levels and any other level map to zero.
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] color_code(input logic [23:0] rgb);
    logic [7:0] r, g, b, lvl;
    logic [2:0] lit;
    r   = rgb[23:16];
    g   = rgb[15:8];
    b   = rgb[7:0];
    lvl = r | g | b;
    lit = {r != 8'h00, g != 8'h00, b != 8'h00};
    if (lit == 3'b000) return 4'd0;
    // any lit channel off the common level breaks the palette
    if ((r != 8'h00 && r != lvl) || (g != 8'h00 && g != lvl) || (b != 8'h00 && b != lvl))
      return 4'd0;
    if (lvl == LVL_FULL) return {1'b1, lit};
    if (lvl == LVL_BRIGHT || lvl == LVL_DARK) return {1'b0, lit};
    return 4'd0;
  endfunction

  // ---------------------------------------------------------------------------
  // Encode one span. Mono: a bit for every nonzero index. Two-color: scan left
  // to right, claim foreground and background first come first served; once
  // both are taken a smaller index pulls the foreground down, and a foreground
  // pulled down to black stops any further unknown color from setting a bit.
  // ---------------------------------------------------------------------------
  function automatic span_code_t encode_span(input bit mode, input span_pix_t px);
    span_code_t res;
    logic [3:0] fg, bg, c;
    bit         fg_set, bg_set, hit;
    res    = '0;
    fg     = '0;
    bg     = '0;
    fg_set = 1'b0;
    bg_set = 1'b0;
    for (int i = 0; i < psc_pkg::NUM_PIXELS; i++) begin
      c   = color_code(px[i]);
      hit = 1'b0;
      if (mode == MODE_COLOR) begin
        if (fg_set && c == fg) begin
          hit = 1'b1;
        end else if (bg_set && c == bg) begin
          hit = 1'b0;
        end else if (c == 4'd0 && !bg_set) begin
          bg     = 4'd0;
          bg_set = 1'b1;
        end else if (!fg_set) begin
          fg     = c;
          fg_set = 1'b1;
          hit    = 1'b1;
        end else if (!bg_set) begin
          bg     = c;
          bg_set = 1'b1;
        end else if (fg != 4'd0) begin
          if (c < fg) fg = c;
          hit = 1'b1;
        end
      end else begin
        hit = (c != 4'd0);
      end
      res.pattern[psc_pkg::NUM_PIXELS-1-i] = hit;
    end
    res.fore = fg_set ? fg : psc_pkg::FG_DEFAULT;
    res.back = bg_set ? bg : psc_pkg::BG_DEFAULT;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check each result strobe against the oldest encoded span, record
  // each accepted span beat and each mode write, and run the watchdog. All in
  // one process so queue order never depends on scheduling within a step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    span_code_t want;
    span_code_t fresh;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        moved = 1'b1;
        if (awaited_codes.size() == 0) begin
          errors++;
          $display("%0t: result with no span pending: pattern %h fore %0d back %0d",
                   $time, out_pattern, out_fore_color, out_back_color);
        end else begin
          want = awaited_codes.pop_front();
          codes_checked++;
          if (out_pattern !== want.pattern) begin
            errors++;
            $display("%0t: pattern expected %h actual %h", $time, want.pattern, out_pattern);
          end
          if (out_fore_color !== want.fore) begin
            errors++;
            $display("%0t: fore_color expected %0d actual %0d", $time, want.fore,
                     out_fore_color);
          end
          if (out_back_color !== want.back) begin
            errors++;
            $display("%0t: back_color expected %0d actual %0d", $time, want.back,
                     out_back_color);
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        fresh = encode_span(color_mode_shadow,
          {in_pixel_0, in_pixel_1, in_pixel_2, in_pixel_3,
           in_pixel_4, in_pixel_5, in_pixel_6, in_pixel_7});
        awaited_codes = {awaited_codes, fresh};
        spans_accepted++;
        if (color_mode_shadow == MODE_COLOR) color_spans++;
        else mono_spans++;
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        color_mode_shadow = cfg_data;
        mode_writes++;
      end
    end
    // count cycles in which nothing at all moved
    if (moved) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d spans still pending", $time,
               awaited_codes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel and span generators.
  // ---------------------------------------------------------------------------
  function automatic logic [23:0] palette_rgb(input int lvl_sel, input logic [2:0] lit);
    logic [7:0] lvl;
    lvl = (lvl_sel == 0) ? LVL_FULL : (lvl_sel == 1) ? LVL_BRIGHT : LVL_DARK;
    return {lit[2] ? lvl : 8'h00, lit[1] ? lvl : 8'h00, lit[0] ? lvl : 8'h00};
  endfunction

  function automatic logic [23:0] any_palette_rgb();
    return palette_rgb($urandom_range(0, 2), 3'($urandom_range(1, 7)));
  endfunction

  function automatic logic [23:0] random_pixel();
    logic [23:0] rgb;
    case ($urandom_range(0, 9))
      0:       rgb = 24'h000000;
      1, 2, 3: rgb = any_palette_rgb();
      // one bit off a palette color
      4:       rgb = any_palette_rgb() ^ (24'h1 << $urandom_range(0, 23));
      // two channels at different levels
      5:       rgb = {LVL_BRIGHT, LVL_DARK, 8'h00} >> (8 * $urandom_range(0, 1));
      default: rgb = 24'($urandom());
    endcase
    return rgb;
  endfunction

  function automatic span_pix_t noise_span();
    span_pix_t s;
    for (int i = 0; i < psc_pkg::NUM_PIXELS; i++) s[i] = random_pixel();
    return s;
  endfunction

  // Span drawn from a small set of palette colors, often with black among them,
  // so that both color slots fill and foreground replacement kicks in.
  function automatic span_pix_t few_color_span();
    logic [3:0][23:0] set_px;
    span_pix_t        s;
    int               n;
    n = $urandom_range(2, 4);
    for (int k = 0; k < 4; k++)
      set_px[k] = (k == 0 && $urandom_range(0, 1)) ? 24'h000000 : any_palette_rgb();
    for (int i = 0; i < psc_pkg::NUM_PIXELS; i++) s[i] = set_px[$urandom_range(0, n - 1)];
    // now and then break the span with a stray pixel
    if ($urandom_range(0, 4) == 0)
      s[$urandom_range(0, psc_pkg::NUM_PIXELS - 1)] = random_pixel();
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; handshakes are sampled on
  // the rising edge.
  // ---------------------------------------------------------------------------

  // Send one span beat. start is left high so the next call can follow back to
  // back; drop it with stop_sending once a run of spans is done.
  task automatic send_span(input span_pix_t px);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        // junk on the pixel ports while start is low must be ignored
        {in_pixel_0, in_pixel_1, in_pixel_2, in_pixel_3,
         in_pixel_4, in_pixel_5, in_pixel_6, in_pixel_7} <= noise_span();
      end
    end
    @(negedge clk);
    start <= 1'b1;
    {in_pixel_0, in_pixel_1, in_pixel_2, in_pixel_3,
     in_pixel_4, in_pixel_5, in_pixel_6, in_pixel_7} <= px;
    // hold until the block takes the beat
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_idle();
    while (awaited_codes.size() != 0) @(negedge clk);
  endtask

  // Write the mode register; only ever called with no span in flight.
  task automatic write_mode(input bit mode);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Mono mode straight out of reset: extremes, every palette color, near misses.
  task automatic test_mono_directed();
    idle_en = 1'b1;
    send_span({8{24'h000000}});
    send_span({8{24'hFFFFFF}});
    send_span({24'h000000, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
               24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF});
    send_span({24'h0000C0, 24'h00C000, 24'h00C0C0, 24'hC00000,
               24'hC000C0, 24'hC0C000, 24'hC0C0C0, 24'hC08000});
    send_span({24'h000080, 24'h008000, 24'h008080, 24'h800000,
               24'h800080, 24'h808000, 24'h808080, 24'hFFFFFE});
    send_span({24'hFEFFFF, 24'hC0C0C1, 24'h7F7F7F, 24'h808081,
               24'h0100FF, 24'hFFFF01, 24'h40C0C0, 24'h00FF80});
    stop_sending();
  endtask

  // Two-color mode: each branch of the scan.
  task automatic test_color_directed();
    write_mode(MODE_COLOR);
    idle_en = 1'b1;
    // all black: black takes the background, foreground stays at its default
    send_span({8{24'h000000}});
    // one color only: background stays at its default
    send_span({8{24'h0000FF}});
    // foreground stepped down twice, larger index still sets a bit
    send_span({24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h0000FF,
               24'hFFFF00, 24'h0000FF, 24'h000000, 24'hFFFFFF});
    // nonzero background, bright and dark of one hue share an index
    send_span({24'hFF0000, 24'h800000, 24'h800000, 24'hFF0000,
               24'h0000C0, 24'hC00000, 24'h00FF00, 24'h800000});
    // black claims the background after the foreground is set
    send_span({24'h00FF00, 24'h00FF00, 24'h000000, 24'h00FF00,
               24'h123456, 24'hFFFFFF, 24'h000000, 24'h00C000});
    // foreground pulled down to black by a later black pixel
    send_span({24'h808080, 24'hC0C0C0, 24'hC0C000, 24'h808000,
               24'hC0C0C0, 24'h000000, 24'h808080, 24'hC0C000});
    // once the foreground is black, only black sets a bit
    send_span({24'h0000FF, 24'hFF0000, 24'h000000, 24'h000000,
               24'h0000FF, 24'hFFFFFF, 24'h800080, 24'h000000});
    // near misses count as black
    send_span({24'hC0C0C1, 24'hC0C0C0, 24'h0A0B0C, 24'hC0C0C0,
               24'hFFFFFF, 24'hFFFFFF, 24'hC0C0C1, 24'h000080});
    send_span(noise_span());
    stop_sending();
  endtask

  // Random spans in one mode, sender idling switched on and off in stretches.
  task automatic test_random_phase(input bit mode, input int count);
    write_mode(mode);
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) idle_en = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) == 0) send_span(noise_span());
      else send_span(few_color_span());
    end
    stop_sending();
  endtask

  // Closing stretch: every cycle carries a span beat, no idling at all.
  task automatic test_streaming(input bit mode, input int count);
    write_mode(mode);
    idle_en = 1'b0;
    for (int i = 0; i < count; i++)
      send_span(($urandom_range(0, 4) == 0) ? noise_span() : few_color_span());
    stop_sending();
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    in_pixel_0 = '0;
    in_pixel_1 = '0;
    in_pixel_2 = '0;
    in_pixel_3 = '0;
    in_pixel_4 = '0;
    in_pixel_5 = '0;
    in_pixel_6 = '0;
    in_pixel_7 = '0;
    idle_en    = 1'b0;
    color_mode_shadow = MODE_MONO;
    errors         = 0;
    spans_accepted = 0;
    mono_spans     = 0;
    color_spans    = 0;
    codes_checked  = 0;
    mode_writes    = 0;
    stall_cycles   = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_mono_directed();
    test_color_directed();
    test_random_phase(MODE_COLOR, 70);
    test_random_phase(MODE_MONO,  70);
    test_random_phase(MODE_COLOR, 70);
    test_random_phase(MODE_COLOR, 70);
    test_random_phase(MODE_MONO,  70);
    test_random_phase(MODE_COLOR, 70);
    test_streaming(MODE_MONO,  40);
    test_streaming(MODE_COLOR, 80);

    // drain, then watch a little longer for stray strobes
    wait_idle();
    repeat (PIPE_LATENCY + 3) @(posedge clk);
    if (awaited_codes.size() != 0) errors++;

    $display("Covered %0d spans (%0d mono, %0d two-color) over %0d mode writes,",
             spans_accepted, mono_spans, color_spans, mode_writes);
    $display("with sender gaps and back-to-back streams; %0d results checked, %0d errors.",
             codes_checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
